/* design/rolling_hash_substring_matcher_defines.svh */
// assertion macros for the rolling hash substring matcher
`ifndef ROLLING_HASH_SUBSTRING_MATCHER_DEFINES_SVH
`define ROLLING_HASH_SUBSTRING_MATCHER_DEFINES_SVH

// same-cycle implication
`define RHSM_ASSERT_NOW(label, clk, rst, cond, expect_expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_expr)) \
    else $error(msg);

// next-cycle implication
`define RHSM_ASSERT_NEXT(label, clk, rst, cond, expect_expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_expr)) \
    else $error(msg);

`endif

/* design/rhsm_pkg.sv */
// shared types and constants for the rolling hash substring matcher
package rhsm_pkg;

  localparam int PATTERN_BYTES = 32;
  localparam int ADDR_W        = 6;
  localparam int DATA_W        = 64;
  localparam int LINE_NUM_W    = 24;
  localparam int POS_W         = 10;
  localparam int HASH_W        = 32;
  localparam int LEN_W         = 6;

  localparam logic [LINE_NUM_W-1:0] LINE_NUM_MAX = {LINE_NUM_W{1'b1}};
  localparam logic [HASH_W-1:0]     HASH_MOD     = {HASH_W{1'b1}};

  typedef enum logic [2:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD_0 = 3'd1,
    REG_PATTERN_WORD_1 = 3'd2,
    REG_PATTERN_WORD_2 = 3'd3,
    REG_PATTERN_WORD_3 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0]                 used_length;
    logic [PATTERN_BYTES-1:0][7:0]    pattern;
  } cfg_t;

endpackage

/* design/rhsm_cfg.sv */
// configuration registers behind the apb port
module rhsm_cfg #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rhsm_pkg::ADDR_W-1:0] paddr,
  input  logic [rhsm_pkg::DATA_W-1:0] pwdata,
  output logic [rhsm_pkg::DATA_W-1:0] prdata,
  output rhsm_pkg::cfg_t              cfg
);

  logic [rhsm_pkg::LEN_W-1:0] pattern_length;
  logic [3:0][63:0]           pattern_word;
  logic [2:0]                 reg_index;
  logic                       wr;

  assign reg_index = paddr[rhsm_pkg::ADDR_W-1:3];
  assign wr        = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= rhsm_pkg::LEN_W'(1);
      pattern_word   <= '0;
    end else if (wr) begin
      case (reg_index)
        rhsm_pkg::REG_PATTERN_LENGTH: pattern_length <= pwdata[rhsm_pkg::LEN_W-1:0];
        rhsm_pkg::REG_PATTERN_WORD_0: pattern_word[0] <= pwdata;
        rhsm_pkg::REG_PATTERN_WORD_1: pattern_word[1] <= pwdata;
        rhsm_pkg::REG_PATTERN_WORD_2: pattern_word[2] <= pwdata;
        rhsm_pkg::REG_PATTERN_WORD_3: pattern_word[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      rhsm_pkg::REG_PATTERN_LENGTH: prdata = rhsm_pkg::DATA_W'(pattern_length);
      rhsm_pkg::REG_PATTERN_WORD_0: prdata = pattern_word[0];
      rhsm_pkg::REG_PATTERN_WORD_1: prdata = pattern_word[1];
      rhsm_pkg::REG_PATTERN_WORD_2: prdata = pattern_word[2];
      rhsm_pkg::REG_PATTERN_WORD_3: prdata = pattern_word[3];
      default:                      prdata = '0;
    endcase
  end

  // zero counts as one, anything above the window depth as the depth
  always_comb begin
    if (pattern_length == '0) begin
      cfg.used_length = rhsm_pkg::LEN_W'(1);
    end else if (pattern_length > rhsm_pkg::LEN_W'(MAX_PATTERN)) begin
      cfg.used_length = rhsm_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      cfg.used_length = pattern_length;
    end
    cfg.pattern = pattern_word;
  end

endmodule

/* design/rhsm_window.sv */
// byte window, position in line and line counter
module rhsm_window #(
  parameter int MAX_PATTERN = 32,
  parameter int MAX_LINE    = 1024,
  localparam int LINE_W     = $clog2(MAX_LINE)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic [7:0]                          text_byte,
  input  logic                                first_of_line,
  output logic [MAX_PATTERN-1:0][7:0]         win,
  output logic [LINE_W-1:0]                   idx,
  output logic [rhsm_pkg::LINE_NUM_W-1:0]     line_number
);

  localparam logic [LINE_W:0] LINE_LAST = (LINE_W+1)'(MAX_LINE - 1);

  logic [MAX_PATTERN-1:0][7:0]     window_bytes;
  logic [MAX_PATTERN-1:0][7:0]     base;
  logic [LINE_W-1:0]               bytes_in_line;
  logic [LINE_W-1:0]               bytes_in_line_next;
  logic [LINE_W:0]                 count;
  logic [rhsm_pkg::LINE_NUM_W-1:0] line_counter;

  always_comb begin
    base = first_of_line ? '0 : window_bytes;
    win[0] = text_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win[j] = base[j-1];
    end
  end

  assign idx   = first_of_line ? '0 : bytes_in_line;
  assign count = {1'b0, idx} + (LINE_W+1)'(1);

  always_comb begin
    if (count >= LINE_LAST) begin
      bytes_in_line_next = LINE_LAST[LINE_W-1:0];
    end else begin
      bytes_in_line_next = count[LINE_W-1:0];
    end
  end

  always_comb begin
    if (first_of_line && line_counter != rhsm_pkg::LINE_NUM_MAX) begin
      line_number = line_counter + rhsm_pkg::LINE_NUM_W'(1);
    end else begin
      line_number = line_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bytes  <= '0;
      bytes_in_line <= '0;
      line_counter  <= '0;
    end else if (step) begin
      window_bytes  <= win;
      bytes_in_line <= bytes_in_line_next;
      line_counter  <= line_number;
    end
  end

endmodule

/* design/rhsm_hash.sv */
// window hash modulo 2^32-1 as an end-around sum of byte-rotated words
module rhsm_hash #(
  parameter int MAX_PATTERN = 32
) (
  input  logic [MAX_PATTERN-1:0][7:0]     win,
  input  logic [rhsm_pkg::LEN_W-1:0]      used_length,
  output logic [rhsm_pkg::HASH_W-1:0]     hash
);

  localparam int NWORDS = (MAX_PATTERN + 3) / 4;
  localparam int SUM_W  = rhsm_pkg::HASH_W + $clog2(NWORDS) + 1;

  logic [NWORDS-1:0][rhsm_pkg::HASH_W-1:0] words;
  logic [SUM_W-1:0]                        sum;
  logic [rhsm_pkg::HASH_W:0]               fold1;
  logic [rhsm_pkg::HASH_W:0]               fold2;

  // 256^4 is 1 modulo 2^32-1, so byte age j lands in lane j mod 4
  always_comb begin
    words = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (rhsm_pkg::LEN_W'(j) < used_length) begin
        words[j >> 2][8*(j & 3) +: 8] = win[j];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NWORDS; i++) begin
      sum = sum + SUM_W'(words[i]);
    end
  end

  always_comb begin
    fold1 = (rhsm_pkg::HASH_W+1)'(sum[rhsm_pkg::HASH_W-1:0])
          + (rhsm_pkg::HASH_W+1)'(sum[SUM_W-1:rhsm_pkg::HASH_W]);
    fold2 = (rhsm_pkg::HASH_W+1)'(fold1[rhsm_pkg::HASH_W-1:0])
          + (rhsm_pkg::HASH_W+1)'(fold1[rhsm_pkg::HASH_W]);
    if (fold2[rhsm_pkg::HASH_W-1:0] == rhsm_pkg::HASH_MOD) begin
      hash = '0;
    end else begin
      hash = fold2[rhsm_pkg::HASH_W-1:0];
    end
  end

endmodule

/* design/rhsm_match.sv */
// exact compare of the aligned window against the pattern
module rhsm_match #(
  parameter int MAX_PATTERN = 32,
  parameter int MAX_LINE    = 1024,
  localparam int LINE_W     = $clog2(MAX_LINE)
) (
  input  logic [MAX_PATTERN-1:0][7:0]                    win,
  input  logic [rhsm_pkg::LEN_W-1:0]                     used_length,
  input  logic [rhsm_pkg::PATTERN_BYTES-1:0][7:0]        pattern,
  input  logic [LINE_W-1:0]                              idx,
  output logic                                           match_found,
  output logic [rhsm_pkg::POS_W-1:0]                     match_position
);

  localparam int CW = (LINE_W + 1 > rhsm_pkg::LEN_W) ? LINE_W + 1 : rhsm_pkg::LEN_W;

  logic [MAX_PATTERN-1:0][7:0] rev;
  logic [MAX_PATTERN-1:0][7:0] aligned;
  logic [rhsm_pkg::LEN_W-1:0]  sh;
  logic [MAX_PATTERN-1:0]      hit;
  logic [CW-1:0]               count;
  logic [CW-1:0]               len_ext;
  logic [CW-1:0]               pos_full;
  logic                        full;

  // oldest byte first, then drop the bytes older than the pattern
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      rev[k] = win[MAX_PATTERN-1-k];
    end
  end

  assign sh      = rhsm_pkg::LEN_W'(MAX_PATTERN) - used_length;
  assign aligned = rev >> {sh, 3'b000};

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      hit[k] = (rhsm_pkg::LEN_W'(k) >= used_length) || (aligned[k] == pattern[k]);
    end
  end

  assign count    = CW'(idx) + CW'(1);
  assign len_ext  = CW'(used_length);
  assign full     = count >= len_ext;
  assign pos_full = count - len_ext;

  assign match_found    = full && (&hit);
  assign match_position = match_found ? rhsm_pkg::POS_W'(pos_full) : '0;

endmodule

/* design/rolling_hash_substring_matcher.sv */
// top level of the rolling hash substring matcher
//
//   channel  | direction | handshake                  | payload
//   text     | in        | text_valid / text_ready    | text_byte, first_of_line
//   result   | out       | result_valid / result_ready| match_found, line_number,
//            |           |                            | match_position, window_hash
//   config   | in        | apb write, pready tied 1   | paddr, pwdata (64 bit)
//
// one byte per cycle sustained while results are not stalled; a taken byte
// passes through the input register and then the result register
// reset clears window, position, line counter and pipeline valids, not the data registers
// a stalled result holds the result register; one more byte can wait in the
// input register, after which text_ready drops
`include "rolling_hash_substring_matcher_defines.svh"

module rolling_hash_substring_matcher #(
  parameter int MAX_PATTERN = 32,
  parameter int MAX_LINE    = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            text_valid,
  output logic                            text_ready,
  input  logic [7:0]                      text_byte,
  input  logic                            first_of_line,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            match_found,
  output logic [rhsm_pkg::LINE_NUM_W-1:0] line_number,
  output logic [rhsm_pkg::POS_W-1:0]      match_position,
  output logic [rhsm_pkg::HASH_W-1:0]     window_hash,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rhsm_pkg::ADDR_W-1:0]     paddr,
  input  logic [rhsm_pkg::DATA_W-1:0]     pwdata,
  output logic [rhsm_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  localparam int LINE_W = $clog2(MAX_LINE);

  rhsm_pkg::cfg_t                  cfg;
  logic                            held;
  logic                            held_next;
  logic [7:0]                      byte_q;
  logic                            first_q;
  logic                            adv;
  logic                            step;
  logic                            take;
  logic [MAX_PATTERN-1:0][7:0]     win;
  logic [LINE_W-1:0]               idx;
  logic [rhsm_pkg::LINE_NUM_W-1:0] line_cur;
  logic [rhsm_pkg::HASH_W-1:0]     hash_cur;
  logic                            match_cur;
  logic [rhsm_pkg::POS_W-1:0]      pos_cur;

  assign pready     = 1'b1;
  assign adv        = !result_valid || result_ready;
  assign step       = held && adv;
  assign text_ready = !held || adv;
  assign take       = text_valid && text_ready;

  always_comb begin
    if (take) begin
      held_next = 1'b1;
    end else if (adv) begin
      held_next = 1'b0;
    end else begin
      held_next = held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_q  <= text_byte;
      first_q <= first_of_line;
    end
  end

  rhsm_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  rhsm_window #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_LINE    (MAX_LINE)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .text_byte     (byte_q),
    .first_of_line (first_q),
    .win           (win),
    .idx           (idx),
    .line_number   (line_cur)
  );

  rhsm_hash #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_hash (
    .win         (win),
    .used_length (cfg.used_length),
    .hash        (hash_cur)
  );

  rhsm_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_LINE    (MAX_LINE)
  ) u_match (
    .win            (win),
    .used_length    (cfg.used_length),
    .pattern        (cfg.pattern),
    .idx            (idx),
    .match_found    (match_cur),
    .match_position (pos_cur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      match_found    <= match_cur;
      line_number    <= line_cur;
      match_position <= pos_cur;
      window_hash    <= hash_cur;
    end
  end

  `RHSM_ASSERT_NOW(a_hash_reduced, clk, rst, result_valid, window_hash != rhsm_pkg::HASH_MOD, "window hash not fully reduced")
  `RHSM_ASSERT_NOW(a_pos_zero, clk, rst, result_valid && !match_found, match_position == '0, "position set without a match")
  `RHSM_ASSERT_NEXT(a_step_result, clk, rst, step, result_valid, "processed byte gave no result")
  `RHSM_ASSERT_NEXT(a_held_kept, clk, rst, held && !adv, held && $stable(byte_q) && $stable(first_q), "waiting byte lost or overwritten")

endmodule

/* bench/testbench.sv */
// self-checking testbench for the rolling hash substring matcher
module testbench;

  localparam int CLK_PERIOD     = 8;
  localparam int LINE_LIMIT     = 1024;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_LIMIT    = 1000;
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int DIRECTED_LEN   = 36;
  localparam int PHASE_ITEMS    = 80;
  localparam int LONG_LINE      = 1030;
  localparam int RANDOM_ITEMS   = 1530;
  localparam logic [2:0] UNUSED_REG = 3'd5;

  typedef struct packed {
    logic                            found;
    logic [rhsm_pkg::LINE_NUM_W-1:0] line;
    logic [rhsm_pkg::POS_W-1:0]      pos;
    logic [rhsm_pkg::HASH_W-1:0]     hash;
  } match_result_t;

  typedef enum logic {ROW_TEXT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [2:0]    reg_sel;
    logic [63:0]   value;
    logic [7:0]    text;
    logic          first;
    logic          typed;
    match_result_t want;
  } directed_row_t;

  typedef enum logic [1:0] {WORDS_ALPHABET, WORDS_RANDOM, WORDS_ONES, WORDS_ZEROS} word_mode_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            text_valid;
  logic                            text_ready;
  logic [7:0]                      text_byte;
  logic                            first_of_line;
  logic                            result_valid;
  logic                            result_ready;
  logic                            match_found;
  logic [rhsm_pkg::LINE_NUM_W-1:0] line_number;
  logic [rhsm_pkg::POS_W-1:0]      match_position;
  logic [rhsm_pkg::HASH_W-1:0]     window_hash;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [rhsm_pkg::ADDR_W-1:0]     paddr;
  logic [rhsm_pkg::DATA_W-1:0]     pwdata;
  logic [rhsm_pkg::DATA_W-1:0]     prdata;
  logic                            pready;

  logic                  row_typed;
  match_result_t         row_expect;
  logic                  burst;
  logic                  long_hold;
  int                    mismatch_count;
  int                    random_sent;
  match_result_t         expected_results [$];
  directed_row_t         directed_rows [DIRECTED_LEN];

  logic [5:0]                      cfg_length;
  logic [63:0]                     pattern_words [4];
  logic [7:0]                      recent_bytes [rhsm_pkg::PATTERN_BYTES];
  int                              line_pos;
  logic [rhsm_pkg::LINE_NUM_W-1:0] line_count;

  rolling_hash_substring_matcher DUT (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_ready    (text_ready),
    .text_byte     (text_byte),
    .first_of_line (first_of_line),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .match_found   (match_found),
    .line_number   (line_number),
    .match_position(match_position),
    .window_hash   (window_hash),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int used_len();
    if (cfg_length == 6'd0) return 1;
    if (cfg_length > rhsm_pkg::PATTERN_BYTES) return rhsm_pkg::PATTERN_BYTES;
    return int'(cfg_length);
  endfunction

  function automatic logic [7:0] pattern_byte(input int k);
    return pattern_words[k >> 3][8 * (k & 7) +: 8];
  endfunction

  function automatic logic [rhsm_pkg::HASH_W-1:0] hash_shift_in(
      input logic [rhsm_pkg::HASH_W-1:0] h, input logic [7:0] b);
    logic [63:0] t;
    t = {32'd0, h} * 64'd256 + {56'd0, b};
    return rhsm_pkg::HASH_W'(t % {32'd0, rhsm_pkg::HASH_MOD});
  endfunction

  function automatic match_result_t scan_text_byte(input logic [7:0] b, input logic f);
    match_result_t r;
    int m, idx, filled, span, k;
    logic [rhsm_pkg::HASH_W-1:0] ph;
    m = used_len();
    if (f) begin
      for (k = 0; k < rhsm_pkg::PATTERN_BYTES; k++) recent_bytes[k] = 8'h00;
      line_pos = 0;
      if (line_count != rhsm_pkg::LINE_NUM_MAX) line_count++;
    end
    idx = line_pos;
    for (k = rhsm_pkg::PATTERN_BYTES - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
    recent_bytes[0] = b;
    filled = (idx + 1 > rhsm_pkg::PATTERN_BYTES) ? rhsm_pkg::PATTERN_BYTES : idx + 1;
    span = (filled < m) ? filled : m;
    r = '0;
    for (k = span; k > 0; k--) r.hash = hash_shift_in(r.hash, recent_bytes[k-1]);
    if (idx + 1 >= m) begin
      ph = '0;
      for (k = 0; k < m; k++) ph = hash_shift_in(ph, pattern_byte(k));
      if (ph == r.hash) begin
        r.found = 1'b1;
        for (k = 0; k < m; k++) begin
          if (recent_bytes[m-1-k] != pattern_byte(k)) r.found = 1'b0;
        end
      end
      if (r.found) r.pos = rhsm_pkg::POS_W'(idx + 1 - m);
    end
    line_pos = (idx + 1 < LINE_LIMIT - 1) ? idx + 1 : LINE_LIMIT - 1;
    r.line = line_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    match_result_t e;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", 64'd0, 64'd1);
        end else begin
          e = expected_results.pop_front();
          if (match_found !== e.found) report_mismatch("match_found", e.found, match_found);
          if (line_number !== e.line) report_mismatch("line_number", e.line, line_number);
          if (match_position !== e.pos)
            report_mismatch("match_position", e.pos, match_position);
          if (window_hash !== e.hash) report_mismatch("window_hash", e.hash, window_hash);
        end
      end
      if (text_valid && text_ready) begin
        e = scan_text_byte(text_byte, first_of_line);
        expected_results.push_back(row_typed ? row_expect : e);
      end
    end
  end

  task automatic wait_drain();
    int waited;
    waited = 0;
    @(posedge clk);
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic f, input logic typed,
                           input match_result_t want);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid    <= 1'b1;
    text_byte     <= b;
    first_of_line <= f;
    row_typed     <= typed;
    row_expect    <= want;
    do @(posedge clk); while (!(text_valid && text_ready));
  endtask

  task automatic apb_write(input logic [2:0] sel, input logic [63:0] value);
    logic [63:0] want;
    text_valid <= 1'b0;
    wait_drain();
    repeat (2) @(posedge clk);
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == rhsm_pkg::REG_PATTERN_LENGTH) cfg_length = value[5:0];
    else if (sel <= rhsm_pkg::REG_PATTERN_WORD_3)
      pattern_words[sel - rhsm_pkg::REG_PATTERN_WORD_0] = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    want = (sel == rhsm_pkg::REG_PATTERN_LENGTH) ? {58'd0, value[5:0]} : value;
    if (sel <= rhsm_pkg::REG_PATTERN_WORD_3 && prdata !== want)
      report_mismatch("register readback", want, prdata);
  endtask

  task automatic send_line(input int len, input logic start);
    logic [7:0] line_bytes [$];
    logic [7:0] piece [rhsm_pkg::PATTERN_BYTES];
    logic [7:0] tmp;
    int m, k, s, r, cut;
    m = used_len();
    while (line_bytes.size() < len) begin
      r = $urandom_range(0, 9);
      if (r <= 3) begin
        for (k = 0; k < m; k++) piece[k] = pattern_byte(k);
        // swapping bytes four apart keeps the hash, so this gives a false candidate unless the two bytes are equal
        if (r == 3 && m > 4) begin
          s = $urandom_range(0, m - 5);
          tmp = piece[s];
          piece[s] = piece[s+4];
          piece[s+4] = tmp;
        end
        cut = (r == 2) ? $urandom_range(1, m) : m;
        for (k = 0; k < cut; k++) line_bytes.push_back(piece[k]);
      end else if (r <= 7) begin
        line_bytes.push_back(pattern_byte($urandom_range(0, m - 1)));
      end else begin
        line_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    for (k = 0; k < len; k++) send_byte(line_bytes[k], start && k == 0, 1'b0, '0);
  endtask

  function automatic directed_row_t text_row(input logic [7:0] b, input logic f);
    directed_row_t row;
    row = '0;
    row.kind  = ROW_TEXT;
    row.text  = b;
    row.first = f;
    return row;
  endfunction

  function automatic directed_row_t typed_row(input logic [7:0] b, input logic f,
                                              input logic found, input int line,
                                              input int pos, input logic [31:0] hash);
    directed_row_t row;
    row = text_row(b, f);
    row.typed = 1'b1;
    row.want  = '{found, rhsm_pkg::LINE_NUM_W'(line), rhsm_pkg::POS_W'(pos), hash};
    return row;
  endfunction

  function automatic directed_row_t write_row(input logic [2:0] sel, input logic [63:0] v);
    directed_row_t row;
    row = '0;
    row.kind    = ROW_WRITE;
    row.reg_sel = sel;
    row.value   = v;
    return row;
  endfunction

  initial begin : result_sink
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = burst ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("[rolling_hash_substring_matcher] ERROR");
    $finish;
  end

  initial begin : stimulus
    int i, p, w, k, len, phase_sent;
    logic [63:0] word;
    logic [7:0] alpha [3];
    int phase_len [8];
    word_mode_t phase_mode [8];
    word_mode_t mode;

    rst           <= 1'b1;
    text_valid    <= 1'b0;
    text_byte     <= 8'h00;
    first_of_line <= 1'b0;
    result_ready  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    row_typed     <= 1'b0;
    row_expect    <= '0;
    burst          = 1'b0;
    long_hold      = 1'b0;
    mismatch_count = 0;
    random_sent    = 0;
    cfg_length     = 6'd1;
    for (k = 0; k < 4; k++) pattern_words[k] = '0;
    for (k = 0; k < rhsm_pkg::PATTERN_BYTES; k++) recent_bytes[k] = 8'h00;
    line_pos   = 0;
    line_count = '0;

    directed_rows = '{
      typed_row(8'h00, 1'b0, 1'b1, 0, 0, 32'd0),   // byte before any line start
      typed_row(8'hFF, 1'b1, 1'b0, 1, 0, 32'd255),
      typed_row(8'h00, 1'b0, 1'b1, 1, 1, 32'd0),
      write_row(UNUSED_REG, 64'hFFFF_FFFF_FFFF_FFFF),
      typed_row(8'h00, 1'b1, 1'b1, 2, 0, 32'd0),
      write_row(rhsm_pkg::REG_PATTERN_LENGTH, 64'd0),
      write_row(rhsm_pkg::REG_PATTERN_WORD_0, 64'h41),
      typed_row(8'h41, 1'b1, 1'b1, 3, 0, 32'd65),
      write_row(rhsm_pkg::REG_PATTERN_LENGTH, 64'd5),
      write_row(rhsm_pkg::REG_PATTERN_WORD_0, 64'h0000_0045_4443_4241),
      text_row(8'h45, 1'b1),                        // hash hit with bytes swapped
      text_row(8'h42, 1'b0),
      text_row(8'h43, 1'b0),
      text_row(8'h44, 1'b0),
      text_row(8'h41, 1'b0),
      text_row(8'h42, 1'b0),
      text_row(8'h43, 1'b0),
      text_row(8'h44, 1'b0),
      text_row(8'h45, 1'b0),
      write_row(rhsm_pkg::REG_PATTERN_LENGTH, 64'd4),
      write_row(rhsm_pkg::REG_PATTERN_WORD_0, 64'd0),
      text_row(8'hFF, 1'b1),
      text_row(8'hFF, 1'b0),
      text_row(8'hFF, 1'b0),
      typed_row(8'hFF, 1'b0, 1'b0, 5, 0, 32'd0),   // all ones folds to zero hash
      text_row(8'h00, 1'b0),
      text_row(8'h00, 1'b0),
      text_row(8'h00, 1'b0),
      text_row(8'h00, 1'b0),
      write_row(rhsm_pkg::REG_PATTERN_LENGTH, 64'd63),
      write_row(rhsm_pkg::REG_PATTERN_WORD_0, 64'hFFFF_FFFF_FFFF_FFFF),
      write_row(rhsm_pkg::REG_PATTERN_WORD_1, 64'd0),
      write_row(rhsm_pkg::REG_PATTERN_WORD_2, 64'h0123_4567_89AB_CDEF),
      write_row(rhsm_pkg::REG_PATTERN_WORD_3, 64'hFFFF_FFFF_FFFF_FFFF),
      typed_row(8'hFF, 1'b1, 1'b0, 6, 0, 32'd255),
      text_row(8'h0A, 1'b0)
    };
    phase_len  = '{1, 32, 63, 0, 5, 4, 17, 0};
    phase_mode = '{WORDS_ALPHABET, WORDS_ALPHABET, WORDS_RANDOM, WORDS_ALPHABET,
                   WORDS_ALPHABET, WORDS_ZEROS, WORDS_ONES, WORDS_ALPHABET};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIRECTED_LEN; i++) begin
      if (directed_rows[i].kind == ROW_WRITE)
        apb_write(directed_rows[i].reg_sel, directed_rows[i].value);
      else
        send_byte(directed_rows[i].text, directed_rows[i].first, directed_rows[i].typed,
                  directed_rows[i].want);
    end

    p = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (p < 7) begin
        len  = phase_len[p];
        mode = phase_mode[p];
      end else begin
        len  = $urandom_range(1, 32);
        mode = (p % 2 == 0) ? WORDS_ALPHABET : WORDS_RANDOM;
      end
      for (k = 0; k < 3; k++) alpha[k] = 8'($urandom_range(0, 255));
      apb_write(rhsm_pkg::REG_PATTERN_LENGTH, 64'(len));
      for (w = 0; w < 4; w++) begin
        for (k = 0; k < 8; k++) begin
          case (mode)
            WORDS_ALPHABET: word[8*k +: 8] = alpha[$urandom_range(0, 2)];
            WORDS_RANDOM:   word[8*k +: 8] = 8'($urandom_range(0, 255));
            WORDS_ONES:     word[8*k +: 8] = 8'hFF;
            default:        word[8*k +: 8] = 8'h00;
          endcase
        end
        apb_write(3'(rhsm_pkg::REG_PATTERN_WORD_0 + w), word);
      end
      phase_sent = 0;
      if (p == 1) begin
        // long line runs the position into saturation
        send_line(LONG_LINE, 1'b1);
        phase_sent  += LONG_LINE;
        random_sent += LONG_LINE;
      end
      if (p == 2) begin
        // receiver stalls while input keeps coming
        long_hold = 1'b1;
        burst     = 1'b1;
        send_line(40, 1'b1);
        burst     = 1'b0;
        phase_sent  += 40;
        random_sent += 40;
      end
      while (phase_sent < PHASE_ITEMS && random_sent < RANDOM_ITEMS) begin
        len   = $urandom_range(1, 2 * used_len() + 8);
        burst = ($urandom_range(0, 5) == 0);
        send_line(len, $urandom_range(0, 7) != 0);
        burst = 1'b0;
        phase_sent  += len;
        random_sent += len;
        if (p == 3 && phase_sent == len) begin
          text_valid <= 1'b0;
          wait_drain();
        end
      end
      p++;
    end

    text_valid <= 1'b0;
    wait_drain();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 64'd0, 64'(expected_results.size()));
    if (mismatch_count == 0)
      $display("[rolling_hash_substring_matcher] OK");
    else
      $display("[rolling_hash_substring_matcher] ERROR");
    $finish;
  end

endmodule
